// ===== rtl/core/lksm_pkg.sv =====
// shared types and constants of the leader key sequence matcher
`timescale 1ns / 1ps

package lksm_pkg;

   localparam int DICT_ENTRIES = 32;
   localparam int MAX_SEQ_LEN  = 16;
   localparam int SLOTS        = MAX_SEQ_LEN + 2;
   localparam int HELD_KEYS    = MAX_SEQ_LEN + 1;
   localparam int KEY_W        = 16;
   localparam int CSR_W        = 16;
   localparam int ROW_W        = (DICT_ENTRIES > 1) ? $clog2(DICT_ENTRIES) : 1;
   localparam int SLOT_W       = $clog2(SLOTS);
   localparam int POS_W        = $clog2(HELD_KEYS);
   localparam int ENTRY_IDX_W  = 5;
   localparam int SLOT_IDX_W   = 5;
   localparam int CSR_IDX_W    = 2;

   localparam logic [KEY_W-1:0] TIMEOUT_RESET     = KEY_W'(1000);
   localparam logic [KEY_W-1:0] LEADER_LOW_RESET  = '1;
   localparam logic [KEY_W-1:0] LEADER_HIGH_RESET = '0;

   typedef enum logic [1:0] {
      CMD_KEY   = 2'd0,
      CMD_TICK  = 2'd1,
      CMD_WRITE = 2'd2
   } cmd_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_TIMEOUT     = 2'd0,
      CSR_LEADER_LOW  = 2'd1,
      CSR_LEADER_HIGH = 2'd2
   } csr_index_type;

   typedef enum logic [1:0] {
      SCAN_NONE    = 2'd0,
      SCAN_PARTIAL = 2'd1,
      SCAN_FULL    = 2'd2
   } scan_kind_type;

   typedef enum logic [1:0] {
      ST_CLEAR = 2'd0,
      ST_IDLE  = 2'd1,
      ST_SCAN  = 2'd2
   } state_type;

   typedef struct packed {
      logic clear_step;
      logic dict_write;
      logic seq_open;
      logic seq_append;
      logic seq_close;
      logic idle_tick;
      logic scan_start;
      logic rsp_load;
      logic rsp_consumed;
      logic rsp_fired;
      logic rsp_timed_out;
   } dp_cmd_type;

   typedef struct packed {
      logic          open_flag;
      logic          leader_hit;
      logic          seq_full;
      logic          idle_expire;
      logic          scan_done;
      scan_kind_type scan_kind;
      logic          clear_last;
   } dp_status_type;

endpackage

// ===== rtl/core/lksm_ctrl.sv =====
// controller state machine of the leader key sequence matcher
`timescale 1ns / 1ps

module lksm_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   input  logic [1:0]              req_command,
   input  logic                    req_key_released,
   input  logic                    req_injected,
   input  logic                    req_already_handled,
   output logic                    req_stall,
   output logic                    rsp_valid,
   input  logic                    rsp_stall,
   input  lksm_pkg::dp_status_type status,
   output lksm_pkg::dp_cmd_type    cmd
);

   lksm_pkg::state_type state_ff, state_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic out_free;
   logic accept;
   logic live_key;

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign req_stall = !((state_ff == lksm_pkg::ST_IDLE) && out_free);
   assign accept    = req_valid && !req_stall;
   assign live_key  = !req_key_released && !req_injected && !req_already_handled;
   assign rsp_valid = rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= lksm_pkg::ST_CLEAR;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         lksm_pkg::ST_CLEAR: begin
            cmd.clear_step = 1'b1;
            if (status.clear_last) begin
               state_in = lksm_pkg::ST_IDLE;
            end
         end
         lksm_pkg::ST_IDLE: begin
            if (accept) begin
               cmd.rsp_load = 1'b1;
               case (lksm_pkg::cmd_type'(req_command))
                  lksm_pkg::CMD_KEY: begin
                     if (live_key) begin
                        if (!status.open_flag) begin
                           if (status.leader_hit) begin
                              cmd.seq_open     = 1'b1;
                              cmd.rsp_consumed = 1'b1;
                           end
                        end else if (status.seq_full) begin
                           cmd.seq_close = 1'b1;
                        end else begin
                           cmd.seq_append = 1'b1;
                           cmd.scan_start = 1'b1;
                           cmd.rsp_load   = 1'b0;
                           state_in       = lksm_pkg::ST_SCAN;
                        end
                     end
                  end
                  lksm_pkg::CMD_TICK: begin
                     if (status.open_flag) begin
                        cmd.idle_tick = 1'b1;
                        if (status.idle_expire) begin
                           cmd.seq_close     = 1'b1;
                           cmd.rsp_timed_out = 1'b1;
                        end
                     end
                  end
                  lksm_pkg::CMD_WRITE: begin
                     cmd.dict_write = 1'b1;
                  end
                  default: begin
                  end
               endcase
            end
         end
         lksm_pkg::ST_SCAN: begin
            if (status.scan_done && out_free) begin
               cmd.rsp_load     = 1'b1;
               cmd.rsp_consumed = (status.scan_kind != lksm_pkg::SCAN_NONE);
               cmd.rsp_fired    = (status.scan_kind == lksm_pkg::SCAN_FULL);
               cmd.seq_close    = (status.scan_kind != lksm_pkg::SCAN_PARTIAL);
               state_in         = lksm_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = lksm_pkg::ST_IDLE;
         end
      endcase
   end

   always_comb begin
      if (cmd.rsp_load) begin
         rsp_valid_in = 1'b1;
      end else begin
         rsp_valid_in = rsp_valid_ff && rsp_stall;
      end
   end

   a_no_accept_in_clear: assert property (@(posedge clock) disable iff (reset)
      (state_ff == lksm_pkg::ST_CLEAR) |-> req_stall)
      else $error("input transfer allowed during dictionary clear");

   a_load_needs_free_output: assert property (@(posedge clock) disable iff (reset)
      cmd.rsp_load |-> out_free)
      else $error("result loaded over a pending result");

   a_scan_follows_start: assert property (@(posedge clock) disable iff (reset)
      cmd.scan_start |=> (state_ff == lksm_pkg::ST_SCAN))
      else $error("scan start without scan state");

   a_scan_blocks_input: assert property (@(posedge clock) disable iff (reset)
      (state_ff == lksm_pkg::ST_SCAN) |-> req_stall)
      else $error("input transfer allowed during scan");

   a_fire_closes: assert property (@(posedge clock) disable iff (reset)
      cmd.rsp_fired |-> (cmd.seq_close && cmd.rsp_consumed))
      else $error("full match without close");

endmodule

// ===== rtl/core/lksm_datapath.sv =====
// datapath of the leader key sequence matcher: dictionary, held keys, scan and result
`timescale 1ns / 1ps

module lksm_datapath (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  csr_wr_en,
   input  logic [lksm_pkg::CSR_IDX_W-1:0]        csr_index,
   input  logic [lksm_pkg::CSR_W-1:0]            csr_wdata,
   input  logic [lksm_pkg::KEY_W-1:0]            req_key_code,
   input  logic [lksm_pkg::ENTRY_IDX_W-1:0]      req_entry_index,
   input  logic [lksm_pkg::SLOT_IDX_W-1:0]       req_slot_index,
   input  lksm_pkg::dp_cmd_type                  cmd,
   output lksm_pkg::dp_status_type               status,
   output logic                                  rsp_consumed,
   output logic                                  rsp_action_fired,
   output logic [lksm_pkg::ENTRY_IDX_W-1:0]      rsp_action_index,
   output logic                                  rsp_sequence_open,
   output logic                                  rsp_timed_out
);

   typedef logic [lksm_pkg::SLOTS-1:0][lksm_pkg::KEY_W-1:0] row_type;

   row_type dict_mem [lksm_pkg::DICT_ENTRIES];

   logic [lksm_pkg::KEY_W-1:0] timeout_ff, leader_low_ff, leader_high_ff;
   logic [lksm_pkg::KEY_W-1:0] held_ff [lksm_pkg::HELD_KEYS];
   logic                       open_ff, open_in;
   logic [lksm_pkg::POS_W-1:0] pos_ff, pos_in;
   logic [lksm_pkg::KEY_W-1:0] idle_ff, idle_in, idle_inc;
   logic [lksm_pkg::ROW_W-1:0] clr_ff, clr_in;

   logic [lksm_pkg::ROW_W:0]   scan_addr_ff, scan_addr_in;
   logic                       scan_active_ff, scan_active_in;
   logic                       chk_vld_ff, chk_vld_in;
   logic [lksm_pkg::ROW_W-1:0] chk_idx_ff;
   row_type                    rd_data_ff;
   logic                       done_ff, done_in;
   lksm_pkg::scan_kind_type    kind_ff, kind_in;
   logic [lksm_pkg::ROW_W-1:0] hit_ff, hit_in;

   logic                       slot0_zero, row_match, next_zero, last_row, done_now;
   logic                       wr_ok;
   logic [lksm_pkg::POS_W-1:0] append_pos;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         timeout_ff     <= lksm_pkg::TIMEOUT_RESET;
         leader_low_ff  <= lksm_pkg::LEADER_LOW_RESET;
         leader_high_ff <= lksm_pkg::LEADER_HIGH_RESET;
      end else if (csr_wr_en) begin
         unique case (lksm_pkg::csr_index_type'(csr_index))
            lksm_pkg::CSR_TIMEOUT:     timeout_ff     <= csr_wdata;
            lksm_pkg::CSR_LEADER_LOW:  leader_low_ff  <= csr_wdata;
            lksm_pkg::CSR_LEADER_HIGH: leader_high_ff <= csr_wdata;
            default: begin
            end
         endcase
      end
   end

   // dictionary memory, cleared row by row after reset while input is stalled
   assign wr_ok = (int'(req_entry_index) < lksm_pkg::DICT_ENTRIES) &&
                  (int'(req_slot_index) < lksm_pkg::SLOTS);

   always_ff @(posedge clock) begin
      if (cmd.clear_step) begin
         dict_mem[clr_ff] <= '0;
      end else if (cmd.dict_write && wr_ok) begin
         dict_mem[lksm_pkg::ROW_W'(req_entry_index)][lksm_pkg::SLOT_W'(req_slot_index)]
            <= req_key_code;
      end
      rd_data_ff <= dict_mem[scan_addr_ff[lksm_pkg::ROW_W-1:0]];
   end

   assign clr_in = cmd.clear_step ? clr_ff + lksm_pkg::ROW_W'(1) : clr_ff;

   // held keys
   assign append_pos = pos_ff + lksm_pkg::POS_W'(1);

   always_ff @(posedge clock) begin
      for (int i = 0; i < lksm_pkg::HELD_KEYS; i++) begin
         if ((cmd.seq_open && i == 0) ||
             (cmd.seq_append && i == int'(append_pos))) begin
            held_ff[i] <= req_key_code;
         end
      end
   end

   // sequence state
   assign idle_inc = (idle_ff == '1) ? idle_ff : idle_ff + lksm_pkg::KEY_W'(1);

   always_comb begin
      open_in = open_ff;
      pos_in  = pos_ff;
      idle_in = idle_ff;
      if (cmd.seq_open) begin
         open_in = 1'b1;
         pos_in  = '0;
         idle_in = '0;
      end
      if (cmd.seq_append) begin
         pos_in  = append_pos;
         idle_in = '0;
      end
      if (cmd.idle_tick) begin
         idle_in = idle_inc;
      end
      if (cmd.seq_close) begin
         open_in = 1'b0;
         pos_in  = '0;
      end
   end

   // scan: one row read per cycle, the row read in the previous cycle checked
   always_comb begin
      slot0_zero = (rd_data_ff[0] == '0);
      row_match  = 1'b1;
      for (int i = 0; i < lksm_pkg::HELD_KEYS; i++) begin
         if ((i <= int'(pos_ff)) && (held_ff[i] != rd_data_ff[i])) begin
            row_match = 1'b0;
         end
      end
      next_zero = (rd_data_ff[lksm_pkg::SLOT_W'(pos_ff) + lksm_pkg::SLOT_W'(1)] == '0);
      last_row  = (chk_idx_ff == lksm_pkg::ROW_W'(lksm_pkg::DICT_ENTRIES - 1));
      done_now  = chk_vld_ff && (slot0_zero || row_match || last_row);
   end

   always_comb begin
      scan_addr_in   = scan_addr_ff;
      scan_active_in = scan_active_ff;
      chk_vld_in     = 1'b0;
      done_in        = done_ff;
      kind_in        = kind_ff;
      hit_in         = hit_ff;
      if (cmd.scan_start) begin
         scan_addr_in   = '0;
         scan_active_in = 1'b1;
         done_in        = 1'b0;
      end else if (scan_active_ff) begin
         if (done_now) begin
            scan_active_in = 1'b0;
            done_in        = 1'b1;
            hit_in         = chk_idx_ff;
            if (slot0_zero || !row_match) begin
               kind_in = lksm_pkg::SCAN_NONE;
            end else if (next_zero) begin
               kind_in = lksm_pkg::SCAN_FULL;
            end else begin
               kind_in = lksm_pkg::SCAN_PARTIAL;
            end
         end else if (int'(scan_addr_ff) < lksm_pkg::DICT_ENTRIES) begin
            chk_vld_in   = 1'b1;
            scan_addr_in = scan_addr_ff + (lksm_pkg::ROW_W + 1)'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         open_ff        <= 1'b0;
         pos_ff         <= '0;
         idle_ff        <= '0;
         clr_ff         <= '0;
         scan_addr_ff   <= '0;
         scan_active_ff <= 1'b0;
         chk_vld_ff     <= 1'b0;
         done_ff        <= 1'b0;
      end else begin
         open_ff        <= open_in;
         pos_ff         <= pos_in;
         idle_ff        <= idle_in;
         clr_ff         <= clr_in;
         scan_addr_ff   <= scan_addr_in;
         scan_active_ff <= scan_active_in;
         chk_vld_ff     <= chk_vld_in;
         done_ff        <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      chk_idx_ff <= scan_addr_ff[lksm_pkg::ROW_W-1:0];
      kind_ff    <= kind_in;
      hit_ff     <= hit_in;
   end

   // result register
   always_ff @(posedge clock) begin
      if (cmd.rsp_load) begin
         rsp_consumed      <= cmd.rsp_consumed;
         rsp_action_fired  <= cmd.rsp_fired;
         rsp_action_index  <= cmd.rsp_fired ? lksm_pkg::ENTRY_IDX_W'(hit_ff) : '0;
         rsp_sequence_open <= open_in;
         rsp_timed_out     <= cmd.rsp_timed_out;
      end
   end

   // status toward the controller
   always_comb begin
      status.open_flag   = open_ff;
      status.leader_hit  = (req_key_code != '0) && (req_key_code >= leader_low_ff) &&
                           (req_key_code <= leader_high_ff);
      status.seq_full    = (pos_ff == lksm_pkg::POS_W'(lksm_pkg::MAX_SEQ_LEN));
      status.idle_expire = (idle_inc > timeout_ff);
      status.scan_done   = done_ff;
      status.scan_kind   = kind_ff;
      status.clear_last  = (clr_ff == lksm_pkg::ROW_W'(lksm_pkg::DICT_ENTRIES - 1));
   end

endmodule

// ===== rtl/core/leader_key_sequence_matcher_unit.sv =====
// top level of the leader key sequence matcher
// ticks, slot writes and keys that need no scan give their result in the cycle after transfer
// a key that extends an open sequence scans one dictionary row per cycle on the single read port
// throughput: one item at a time; the next item is taken once the unit is idle and the result register is free
// reset: synchronous; afterwards a pass over every dictionary row clears the dictionary, input stalled
`timescale 1ns / 1ps

module leader_key_sequence_matcher_unit (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  csr_wr_en,
   input  logic [lksm_pkg::CSR_IDX_W-1:0]        csr_index,
   input  logic [lksm_pkg::CSR_W-1:0]            csr_wdata,
   input  logic                                  req_valid,
   output logic                                  req_stall,
   input  logic [1:0]                            req_command,
   input  logic [lksm_pkg::KEY_W-1:0]            req_key_code,
   input  logic                                  req_key_released,
   input  logic                                  req_injected,
   input  logic                                  req_already_handled,
   input  logic [lksm_pkg::ENTRY_IDX_W-1:0]      req_entry_index,
   input  logic [lksm_pkg::SLOT_IDX_W-1:0]       req_slot_index,
   output logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   output logic                                  rsp_consumed,
   output logic                                  rsp_action_fired,
   output logic [lksm_pkg::ENTRY_IDX_W-1:0]      rsp_action_index,
   output logic                                  rsp_sequence_open,
   output logic                                  rsp_timed_out
);

   lksm_pkg::dp_cmd_type    dp_cmd;
   lksm_pkg::dp_status_type dp_status;

   lksm_ctrl u_ctrl (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_command         (req_command),
      .req_key_released    (req_key_released),
      .req_injected        (req_injected),
      .req_already_handled (req_already_handled),
      .req_stall           (req_stall),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .status              (dp_status),
      .cmd                 (dp_cmd)
   );

   lksm_datapath u_datapath (
      .clock             (clock),
      .reset             (reset),
      .csr_wr_en         (csr_wr_en),
      .csr_index         (csr_index),
      .csr_wdata         (csr_wdata),
      .req_key_code      (req_key_code),
      .req_entry_index   (req_entry_index),
      .req_slot_index    (req_slot_index),
      .cmd               (dp_cmd),
      .status            (dp_status),
      .rsp_consumed      (rsp_consumed),
      .rsp_action_fired  (rsp_action_fired),
      .rsp_action_index  (rsp_action_index),
      .rsp_sequence_open (rsp_sequence_open),
      .rsp_timed_out     (rsp_timed_out)
   );

endmodule
